### rtl/core/bfir_pkg.sv
// Block FIR filter: shared types and constants.
// Used by bfir_seq, bfir_dp and block_fir_filter_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfir_pkg;

	localparam int TAPS     = 64;
	localparam int TAP_W    = 6;
	localparam int SAMPLE_W = 12;
	localparam int COEF_W   = 18;
	localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
	localparam int ACC_W    = PROD_W + TAP_W;

	typedef enum logic [1:0] {
		OP_FILTER  = 2'd0,
		OP_LOAD_LP = 2'd1,
		OP_LOAD_HP = 2'd2
	} opcode_t;

	typedef struct packed {
		opcode_t                    opcode;
		logic [SAMPLE_W-1:0]        sample_in;
		logic [TAP_W-1:0]           coef_index;
		logic signed [COEF_W-1:0]   coef_value;
	} item_t;

	// control word fields that drive the datapath
	typedef struct packed {
		logic ready;
		logic mac;
		logic emit;
	} ctrl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic sample_fire;
		logic more;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

### rtl/core/block_fir_filter_core.sv
// Block FIR filter top level: stream ports, filter_select register,
// sequencer and datapath. Depends on bfir_pkg, bfir_seq, bfir_dp.
//
// Usage:
//   s_axis carries one item per transaction: tuser is the opcode (filter a
//   sample, load a low-pass or high-pass coefficient). Loads give no result.
//   Each sample gives one result on m_axis; tlast marks the last sample of
//   a block of BLOCK_LEN samples.
//   cfg carries filter_select; write it only while the block is idle.
// Sequence:
//   A sample at block position n runs one MAC step per tap, ntaps = min(n+1, 64),
//   through a single shared multiply-accumulate; the MAC pipeline then drains
//   and the result is loaded into the output register. Only after that is
//   the next item taken.
// Reset:
//   Coefficient tables read as zero, block position and filter_select clear.
//   No clearing pass is needed.
// Stall:
//   A result waits in the output register; if it is still held when the next
//   result is ready, the sequencer waits in its emit step and s_axis_tready
//   stays low.
`timescale 1ns / 1ps
`default_nettype none

module block_fir_filter_core import bfir_pkg::*; #(
	parameter int BLOCK_LEN      = 64,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,  // sample_in[11:0], coef_index[17:12], coef_value[35:18]
	input  wire  [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,  // filtered_out[11:0]
	output logic        m_axis_tlast,  // block_end
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data       // filter_select
);

	ctrl_t               ctrl;
	stat_t               stat;
	item_t               item;
	logic                filter_select_q;
	logic [SAMPLE_W-1:0] out_data;

	assign item.opcode     = opcode_t'(s_axis_tuser);
	assign item.sample_in  = s_axis_tdata[11:0];
	assign item.coef_index = s_axis_tdata[17:12];
	assign item.coef_value = $signed(s_axis_tdata[35:18]);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_select_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			filter_select_q <= cfg_data;
		end
	end

	bfir_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bfir_dp #(
		.BLOCK_LEN      (BLOCK_LEN),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.in_valid      (s_axis_tvalid),
		.item          (item),
		.filter_select (filter_select_q),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_data      (out_data),
		.out_last      (m_axis_tlast)
	);

	assign s_axis_tready = ctrl.ready;
	assign m_axis_tdata  = {4'b0000, out_data};

endmodule

`default_nettype wire

### rtl/core/bfir_seq.sv
// Block FIR filter: microcode sequencer (program ROM, step counter, branches).
// Depends on bfir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfir_seq import bfir_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	typedef enum logic [1:0] {
		COND_NONE,
		COND_NO_SAMPLE,
		COND_MORE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		ctrl_t      ctrl;
		cond_t      cond;
		logic [2:0] jump;
		logic [2:0] next;
	} ucode_t;

	localparam logic [2:0] STEP_FETCH  = 3'd0;
	localparam logic [2:0] STEP_LOOP   = 3'd1;
	localparam logic [2:0] STEP_DRAIN1 = 3'd2;
	localparam logic [2:0] STEP_DRAIN2 = 3'd3;
	localparam logic [2:0] STEP_EMIT   = 3'd4;

	//                           ready mac  emit   cond            jump        next
	localparam ucode_t ROM [8] = '{
		'{'{1'b1, 1'b0, 1'b0}, COND_NO_SAMPLE, STEP_FETCH, STEP_LOOP},
		'{'{1'b0, 1'b1, 1'b0}, COND_MORE,      STEP_LOOP,  STEP_DRAIN1},
		'{'{1'b0, 1'b0, 1'b0}, COND_NONE,      STEP_FETCH, STEP_DRAIN2},
		'{'{1'b0, 1'b0, 1'b0}, COND_NONE,      STEP_FETCH, STEP_EMIT},
		'{'{1'b0, 1'b0, 1'b1}, COND_OUT_BUSY,  STEP_EMIT,  STEP_FETCH},
		'{'{1'b0, 1'b0, 1'b0}, COND_NONE,      STEP_FETCH, STEP_FETCH},
		'{'{1'b0, 1'b0, 1'b0}, COND_NONE,      STEP_FETCH, STEP_FETCH},
		'{'{1'b0, 1'b0, 1'b0}, COND_NONE,      STEP_FETCH, STEP_FETCH}
	};

	logic [2:0] pc_q;
	ucode_t     word;
	logic       take;

	assign word = ROM[pc_q];
	assign ctrl = word.ctrl;

	always_comb begin
		case (word.cond)
			COND_NO_SAMPLE: take = !stat.sample_fire;
			COND_MORE:      take = stat.more;
			COND_OUT_BUSY:  take = stat.out_busy;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= take ? word.jump : word.next;
		end
	end

endmodule

`default_nettype wire

### rtl/core/bfir_dp.sv
// Block FIR filter: datapath (coefficient and history memories, MAC pipeline,
// block position, saturation and output register). Depends on bfir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfir_dp import bfir_pkg::*; #(
	parameter int BLOCK_LEN      = 64,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ctrl_t                ctrl,
	output stat_t                stat,
	input  wire                  in_valid,
	input  item_t                item,
	input  wire                  filter_select,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [SAMPLE_W-1:0]  out_data,
	output logic                 out_last
);

	localparam int POS_W = $clog2(BLOCK_LEN);

	logic [COEF_W-1:0]          coef_mem [2*TAPS];
	logic [2*TAPS-1:0]          coef_vld_q;
	logic [SAMPLE_W-1:0]        hist_mem [TAPS];

	logic                       in_fire;
	logic                       sample_fire;
	logic                       coef_wr;
	logic [TAP_W:0]             coef_wr_addr;
	logic [TAP_W:0]             coef_rd_addr;
	logic [TAP_W-1:0]           hist_rd_addr;

	logic [POS_W-1:0]           pos_q;
	logic [POS_W+TAP_W-1:0]     pos_ext;
	logic [TAP_W-1:0]           pos6;
	logic [TAP_W-1:0]           last_k;
	logic                       pos_last;
	logic [TAP_W-1:0]           k_q;

	logic                       v_s1;
	logic                       v_s2;
	logic [COEF_W-1:0]          coef_s1;
	logic                       cvld_s1;
	logic [SAMPLE_W-1:0]        hist_s1;
	logic signed [COEF_W-1:0]   coef_eff;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       acc_pos;
	logic [ACC_W-1:0]           acc_shift;
	logic [SAMPLE_W-1:0]        sat;
	logic                       emit_go;

	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_last_q;

	assign in_fire      = in_valid && ctrl.ready;
	assign sample_fire  = in_fire && (item.opcode == OP_FILTER);
	assign coef_wr      = in_fire && (item.opcode inside {OP_LOAD_LP, OP_LOAD_HP});
	assign coef_wr_addr = {item.opcode == OP_LOAD_HP, item.coef_index};
	assign coef_rd_addr = {filter_select, k_q};

	assign pos_ext      = {{TAP_W{1'b0}}, pos_q};
	assign pos6         = pos_ext[TAP_W-1:0];
	assign last_k       = (pos_ext >= (POS_W+TAP_W)'(TAPS-1)) ? TAP_W'(TAPS-1) : pos6;
	assign pos_last     = (pos_q == POS_W'(BLOCK_LEN-1));
	assign hist_rd_addr = pos6 - k_q;

	assign stat.sample_fire = sample_fire;
	assign stat.more        = (k_q != last_k);
	assign stat.out_busy    = out_valid_q && !out_ready;

	assign emit_go = ctrl.emit && !stat.out_busy;

	// memories
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[coef_wr_addr] <= item.coef_value;
		end
		coef_s1 <= coef_mem[coef_rd_addr];
		if (sample_fire) begin
			hist_mem[pos6] <= item.sample_in;
		end
		hist_s1 <= hist_mem[hist_rd_addr];
	end

	// unloaded coefficient entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_wr) begin
			coef_vld_q[coef_wr_addr] <= 1'b1;
		end
	end

	assign coef_eff = cvld_s1 ? $signed(coef_s1) : '0;
	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		cvld_s1 <= coef_vld_q[coef_rd_addr];
		prod_s2 <= coef_eff * $signed({1'b0, hist_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= ctrl.mac;
			v_s2 <= v_s1;
			if (sample_fire) begin
				k_q   <= '0;
				acc_q <= '0;
			end else begin
				if (ctrl.mac) begin
					k_q <= k_q + TAP_W'(1);
				end
				if (v_s2) begin
					acc_q <= acc_q + prod_ext;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_last ? '0 : pos_q + POS_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// truncate toward zero, clamp to 0..4095
	assign acc_pos   = !acc_q[ACC_W-1] && (acc_q != '0);
	assign acc_shift = $unsigned(acc_q) >> COEF_FRAC_BITS;

	always_comb begin
		if (!acc_pos) begin
			sat = '0;
		end else if (|acc_shift[ACC_W-1:SAMPLE_W]) begin
			sat = '1;
		end else begin
			sat = acc_shift[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_data_q <= sat;
			out_last_q <= pos_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> (!v_s1 && !v_s2))
		else $error("result loaded while MAC pipeline busy");

	a_fetch_drained: assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |-> (!v_s1 && !v_s2 && !ctrl.mac))
		else $error("sample taken while MAC pipeline busy");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= (POS_W+1)'(BLOCK_LEN-1))
		else $error("block position out of range");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.emit))
		else $error("output valid without emit step");
`endif

endmodule

`default_nettype wire

### tb/sv/block_fir_filter_core_test.sv
// Testbench for block_fir_filter_core: directed and random stream traffic,
// results checked against an in-bench FIR prediction. Depends on bfir_pkg.
`timescale 1ns / 1ps

module block_fir_filter_core_test;
	import bfir_pkg::*;

	localparam int BLOCK_LEN      = 64;
	localparam int COEF_FRAC_BITS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 80;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HOLD_CYCLES    = 700;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} filt_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata = '0;   // sample_in[11:0], coef_index[17:12], coef_value[35:18]
	logic [1:0]   s_axis_tuser = '0;   // opcode[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;        // filtered_out[11:0]
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_data = 1'b0;

	// prediction state
	logic signed [COEF_W-1:0] lp_coefs [TAPS];
	logic signed [COEF_W-1:0] hp_coefs [TAPS];
	logic [SAMPLE_W-1:0]      blk_samples [TAPS];
	int                       blk_pos;
	logic                     sel_highpass;
	filt_result_t             pending_outputs [$];

	int          fault_count;
	int          cycle_count;
	int          burst_left;
	int          hold_request;
	int          hold_left;
	int unsigned rx_phase;
	int          rx_mode;

	block_fir_filter_core #(
		.BLOCK_LEN(BLOCK_LEN),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("block_fir_filter_core_test NOT OK");
			$finish;
		end
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void filter_sample(input logic [SAMPLE_W-1:0] smp);
		longint       acc;
		longint       q;
		int           ntaps;
		filt_result_t r;
		acc = 0;
		blk_samples[blk_pos % TAPS] = smp;
		ntaps = (blk_pos < TAPS - 1) ? blk_pos + 1 : TAPS;
		for (int k = 0; k < ntaps; k++) begin
			acc += longint'(sel_highpass ? hp_coefs[k] : lp_coefs[k])
				* longint'(blk_samples[(blk_pos - k) & (TAPS - 1)]);
		end
		if (acc <= 0) begin
			r.value = '0;
		end else begin
			q = acc >>> COEF_FRAC_BITS;
			r.value = (q > 4095) ? 12'd4095 : q[SAMPLE_W-1:0];
		end
		r.last = (blk_pos + 1 >= BLOCK_LEN);
		blk_pos = r.last ? 0 : blk_pos + 1;
		pending_outputs.push_back(r);
	endfunction

	function automatic void apply_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] smp,
			input logic [TAP_W-1:0] idx, input logic signed [COEF_W-1:0] coef);
		case (op)
			OP_FILTER:  filter_sample(smp);
			OP_LOAD_LP: lp_coefs[idx] = coef;
			OP_LOAD_HP: hp_coefs[idx] = coef;
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		filt_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outputs.size() == 0) begin
				note_fault($sformatf("unexpected result value=%0d last=%0b",
					m_axis_tdata[SAMPLE_W-1:0], m_axis_tlast));
			end else begin
				want = pending_outputs.pop_front();
				if (m_axis_tdata[SAMPLE_W-1:0] !== want.value)
					note_fault($sformatf("filtered_out expected %0d got %0d",
						want.value, m_axis_tdata[SAMPLE_W-1:0]));
				if (m_axis_tlast !== want.last)
					note_fault($sformatf("block_end expected %0b got %0b",
						want.last, m_axis_tlast));
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (rx_phase[7:0] == 8'd0)
			rx_mode = $urandom_range(0, 3);
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= (rx_phase % 3) != 0;
				2: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= rx_phase[4:3] != 2'b00;
			endcase
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] smp,
			input logic [TAP_W-1:0] idx, input logic signed [COEF_W-1:0] coef);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, coef, idx, smp};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		apply_item(op, smp, idx, coef);
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_filter_select(input logic val);
		drain_outputs();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sel_highpass = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [COEF_W-1:0] rand_coef(input int mag, input int bias);
		int v;
		v = int'($urandom_range(0, 2 * mag - 1)) - mag + bias;
		if (v > 131071) v = 131071;
		return COEF_W'(v);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return 12'hFFF;
		return SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	task automatic test_directed_items();
		send_item(OP_FILTER, 12'd4095, 6'd0, 18'sd0);           // empty tables give zero
		send_item(OP_UNUSED, 12'hFFF, 6'h3F, 18'sh1FFFF);      // ignored opcode
		send_item(OP_LOAD_LP, 12'd0, 6'd0, 18'sh1FFFF);        // largest coefficient
		send_item(OP_FILTER, 12'd4095, 6'd0, 18'sd0);          // saturates high
		send_item(OP_LOAD_LP, 12'd0, 6'd1, -18'sd131072);      // smallest coefficient
		send_item(OP_FILTER, 12'd0, 6'd0, 18'sd0);             // negative sum clamps to zero
		send_item(OP_LOAD_LP, 12'd0, 6'd63, 18'sd65536);
		send_item(OP_LOAD_LP, 12'd0, 6'd0, 18'sd65536);
		send_item(OP_LOAD_LP, 12'd0, 6'd1, 18'sd0);
		send_item(OP_FILTER, 12'd1234, 6'd0, 18'sd0);
		send_item(OP_LOAD_LP, 12'd0, 6'd2, 18'sd100);          // fractional part truncated
		send_item(OP_FILTER, 12'd1, 6'd0, 18'sd0);
		send_item(OP_LOAD_HP, 12'd0, 6'd0, 18'sd32768);
		send_item(OP_LOAD_HP, 12'd0, 6'd1, -18'sd32768);
		send_item(OP_LOAD_HP, 12'd0, 6'd63, -18'sd1);
		send_item(OP_FILTER, 12'd2048, 6'd0, 18'sd0);
	endtask

	task automatic test_table_select();
		write_filter_select(1'b1);
		send_item(OP_FILTER, 12'd4000, 6'd0, 18'sd0);
		send_item(OP_FILTER, 12'd100, 6'd0, 18'sd0);
		send_item(OP_LOAD_HP, 12'd0, 6'd2, 18'sd70000);        // load lands mid-block
		send_item(OP_FILTER, 12'd3000, 6'd0, 18'sd0);
		write_filter_select(1'b0);
		send_item(OP_FILTER, 12'd555, 6'd0, 18'sd0);
		send_item(OP_FILTER, 12'd4095, 6'd0, 18'sd0);
	endtask

	task automatic test_random_phase(input logic sel, input int n_items, input bit with_hold);
		int mag;
		int bias;
		int r;
		write_filter_select(sel);
		mag  = 1 << $urandom_range(9, 17);
		bias = $urandom_range(0, 1) ? mag / 4 : 0;
		// fresh table for the active filter, then mixed traffic
		for (int k = 0; k < TAPS; k++)
			send_item(sel ? OP_LOAD_HP : OP_LOAD_LP, rand_sample(), TAP_W'(k),
				rand_coef(mag, bias));
		for (int i = TAPS; i < n_items; i++) begin
			if (with_hold && i == n_items / 2)
				hold_request = HOLD_CYCLES;
			r = $urandom_range(0, 99);
			if (r < 86)
				send_item(OP_FILTER, rand_sample(), TAP_W'($urandom_range(0, 63)),
					rand_coef(mag, 0));
			else if (r < 96)
				send_item($urandom_range(0, 1) ? OP_LOAD_HP : OP_LOAD_LP, rand_sample(),
					TAP_W'($urandom_range(0, 63)), rand_coef(mag, bias));
			else
				send_item(OP_UNUSED, rand_sample(), TAP_W'($urandom_range(0, 63)),
					rand_coef(131072, 0));
		end
	endtask

	task automatic test_random_traffic();
		test_random_phase(1'b0, 300, 1'b0);
		test_random_phase(1'b1, 300, 1'b1);
		test_random_phase(1'b0, 300, 1'b0);
		test_random_phase(1'b1, 300, 1'b0);
		test_random_phase(1'b0, 300, 1'b1);
	endtask

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			lp_coefs[k]    = '0;
			hp_coefs[k]    = '0;
			blk_samples[k] = '0;
		end
		blk_pos      = 0;
		sel_highpass = 1'b0;
		fault_count  = 0;
		cycle_count  = 0;
		burst_left   = 0;
		hold_request = 0;
		hold_left    = 0;
		rx_phase     = 0;
		rx_mode      = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_items();
		test_table_select();
		test_random_traffic();

		drain_outputs();
		if (fault_count == 0 && pending_outputs.size() == 0)
			$display("block_fir_filter_core_test OK");
		else
			$display("block_fir_filter_core_test NOT OK");
		$finish;
	end

endmodule
